@@ hdl/ftld_pkg.sv @@
// ----------------------------------------------------------------------------
// ftld_pkg: shared types and constants of the takeoff and landing detector
// Holds the transfer payload structs, the configuration and state records,
// the flight phase codes and the configuration register indexes.
// ----------------------------------------------------------------------------
package ftld_pkg;

  // Flight phase codes.
  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_FLIGHT = 2'd1,
    PH_LAND   = 2'd2
  } phase_t;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_ALWAYS_START = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_THR    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LAND_THR     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_THR    = 3'd4;

  // Milliseconds in one second, and the width of a timeout in milliseconds.
  localparam logic [17:0] MS_PER_S = 18'd1000;
  localparam int unsigned TmoW     = 18;

  // Reset values of the altitude extremes.
  localparam logic signed [15:0] MAX_ALT_RST = -16'sd32678;
  localparam logic signed [15:0] MIN_ALT_RST = 16'sd32677;

  // One input sample.
  typedef struct packed {
    logic signed [15:0] altitude_m;
    logic signed [15:0] climb_cms;
    logic               baro_valid;
    logic               gps_valid;
    logic [9:0]         speed_kph;
    logic [31:0]        now_ms;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [1:0]         phase;
    logic               took_off;
    logic               landed;
    logic [31:0]        duration_ms;
    logic signed [15:0] peak_alt_m;
    logic signed [15:0] lowest_alt_m;
    logic signed [15:0] best_climb_cms;
    logic signed [15:0] worst_sink_cms;
  } out_item_t;

  // Configuration registers.
  typedef struct packed {
    logic       always_start;
    logic [7:0] start_threshold_m;
    logic [7:0] land_threshold_m;
    logic [7:0] timeout_s;
    logic [7:0] speed_threshold_kph;
  } cfg_t;

  // Detector state carried from one sample to the next.
  typedef struct packed {
    phase_t             phase;
    logic signed [15:0] ref_altitude;
    logic [31:0]        ref_time;
    logic [31:0]        flight_start_time;
    logic signed [15:0] max_altitude;
    logic signed [15:0] min_altitude;
    logic signed [15:0] max_climb_rate;
    logic signed [15:0] max_sink_rate;
  } state_t;

endpackage

@@ hdl/flight_takeoff_landing_detector.sv @@
// ----------------------------------------------------------------------------
// flight_takeoff_landing_detector: takeoff and landing detection per sample
// Flow: a sample transfer loads the input register, and its result then moves
// into the result register, from which it transfers; a stalled result holds
// both registers. Throughput: one sample per cycle while the result channel
// does not stall; the state update from the input register is combinational.
// Reset: synchronous, active low; phase returns to waiting, the reference,
// start time and extremes take their reset values and all settings clear.
// ----------------------------------------------------------------------------
module flight_takeoff_landing_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  // Sample channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ftld_pkg::in_item_t            in_data,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output ftld_pkg::out_item_t           out_data,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ftld_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [7:0]                    cfg_data
);

  ftld_pkg::cfg_t      cfg_r;
  ftld_pkg::state_t    state_r;
  ftld_pkg::state_t    state_nxt;
  ftld_pkg::in_item_t  s1_data_r;
  logic                s1_valid_r;
  ftld_pkg::out_item_t out_data_r;
  ftld_pkg::out_item_t res;
  logic                out_valid_r;
  logic                advance;
  logic                in_take;

  // The input register moves on whenever the result register is free or
  // its contents are being taken in this cycle.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ftld_pkg::CFG_ALWAYS_START: cfg_r.always_start        <= cfg_data[0];
        ftld_pkg::CFG_START_THR:    cfg_r.start_threshold_m   <= cfg_data;
        ftld_pkg::CFG_LAND_THR:     cfg_r.land_threshold_m    <= cfg_data;
        ftld_pkg::CFG_TIMEOUT:      cfg_r.timeout_s           <= cfg_data;
        ftld_pkg::CFG_SPEED_THR:    cfg_r.speed_threshold_kph <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  // Per-sample decision logic.
  ftld_step u_step (
    .cfg    (cfg_r),
    .st     (state_r),
    .item   (s1_data_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  // Detector state, updated once per sample as it enters the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase             <= ftld_pkg::PH_WAIT;
      state_r.ref_altitude      <= '0;
      state_r.ref_time          <= '0;
      state_r.flight_start_time <= '0;
      state_r.max_altitude      <= ftld_pkg::MAX_ALT_RST;
      state_r.min_altitude      <= ftld_pkg::MIN_ALT_RST;
      state_r.max_climb_rate    <= '0;
      state_r.max_sink_rate     <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  // A landing result always reports the landed phase.
  a_landed_phase : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.landed |-> out_data_r.phase == ftld_pkg::PH_LAND)
    else $error("landing result without landed phase");

  // A takeoff result always reports the flying phase and never a landing.
  a_took_phase : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.took_off |->
      out_data_r.phase == ftld_pkg::PH_FLIGHT && !out_data_r.landed)
    else $error("takeoff result with wrong phase or landing");

  // The state changes only when a sample passes into the result register.
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("state changed without a sample");

  // In always mode there is no automatic landing.
  a_no_autoland : assert property (@(posedge clk) disable iff (!rst_n)
    advance && cfg_r.always_start |-> !res.landed)
    else $error("landing detected in always mode");

endmodule

@@ hdl/ftld_step.sv @@
// ----------------------------------------------------------------------------
// ftld_step: next-state and result logic for one sample
// Decides takeoff, reference refresh and landing from the current state and
// one sample, and tracks the altitude and climb extremes while flying.
// ----------------------------------------------------------------------------
module ftld_step (
  input  ftld_pkg::cfg_t     cfg,
  input  ftld_pkg::state_t   st,
  input  ftld_pkg::in_item_t item,
  output ftld_pkg::state_t   st_nxt,
  output ftld_pkg::out_item_t res
);

  logic [ftld_pkg::TmoW-1:0] tmo;
  logic [31:0]               tmo32;
  logic [31:0]               elapsed;
  logic                      tmo_over;
  logic signed [16:0]        diff;
  logic [16:0]               adiff;
  logic                      spd_on;
  logic                      spd_hi;
  logic                      spd_low;
  logic [31:0]               fst_land;

  // Timeout in milliseconds and the time since the reference.
  assign tmo      = {10'd0, cfg.timeout_s} * ftld_pkg::MS_PER_S;
  assign tmo32    = 32'(tmo);
  assign elapsed  = item.now_ms - st.ref_time;
  assign tmo_over = elapsed > tmo32;

  // Distance of the altitude from the reference.
  assign diff  = 17'(item.altitude_m) - 17'(st.ref_altitude);
  assign adiff = diff[16] ? 17'(-diff) : 17'(diff);

  // Speed tests; with no fix or a zero threshold the speed never counts high.
  assign spd_on  = (cfg.speed_threshold_kph != 8'd0) && item.gps_valid;
  assign spd_hi  = spd_on && (item.speed_kph > 10'(cfg.speed_threshold_kph));
  assign spd_low = !spd_on || (item.speed_kph < 10'(cfg.speed_threshold_kph));

  assign fst_land = st.flight_start_time + tmo32;

  // Phase decisions and extremes.
  always_comb begin
    st_nxt          = st;
    res.took_off    = 1'b0;
    res.landed      = 1'b0;
    res.duration_ms = 32'd0;

    if (cfg.always_start) begin
      if (item.baro_valid && st.phase == ftld_pkg::PH_WAIT) begin
        st_nxt.phase             = ftld_pkg::PH_FLIGHT;
        st_nxt.flight_start_time = item.now_ms;
        st_nxt.ref_altitude      = item.altitude_m;
        st_nxt.ref_time          = item.now_ms;
        res.took_off             = 1'b1;
      end
    end else begin
      // On the ground: look for a departure, else refresh the reference once the timeout has passed.
      if (item.baro_valid &&
          (st.phase == ftld_pkg::PH_WAIT || st.phase == ftld_pkg::PH_LAND)) begin
        if (cfg.start_threshold_m != 8'd0 &&
            adiff > 17'(cfg.start_threshold_m) && spd_hi) begin
          st_nxt.phase             = ftld_pkg::PH_FLIGHT;
          st_nxt.flight_start_time = item.now_ms;
          st_nxt.ref_altitude      = item.altitude_m;
          st_nxt.ref_time          = item.now_ms;
          res.took_off             = 1'b1;
        end else if (tmo_over) begin
          st_nxt.ref_time     = item.now_ms;
          st_nxt.ref_altitude = item.altitude_m;
        end
      end
      // In the air: land after staying still for longer than the timeout, else refresh the reference when moving.
      if (st.phase == ftld_pkg::PH_FLIGHT && cfg.land_threshold_m != 8'd0) begin
        if (adiff < 17'(cfg.land_threshold_m) && spd_low) begin
          if (tmo_over) begin
            st_nxt.flight_start_time = fst_land;
            st_nxt.phase             = ftld_pkg::PH_LAND;
            st_nxt.ref_time          = item.now_ms;
            res.duration_ms          = item.now_ms - fst_land;
            res.landed               = 1'b1;
          end
        end else begin
          st_nxt.ref_altitude = item.altitude_m;
          st_nxt.ref_time     = item.now_ms;
        end
      end
    end

    // Extremes follow the phase after this sample.
    if (st_nxt.phase == ftld_pkg::PH_FLIGHT) begin
      if (item.altitude_m > st.max_altitude) st_nxt.max_altitude = item.altitude_m;
      if (item.altitude_m < st.min_altitude) st_nxt.min_altitude = item.altitude_m;
      if (item.climb_cms > st.max_climb_rate) st_nxt.max_climb_rate = item.climb_cms;
      if (item.climb_cms < st.max_sink_rate) st_nxt.max_sink_rate = item.climb_cms;
    end

    res.phase          = st_nxt.phase;
    res.peak_alt_m     = st_nxt.max_altitude;
    res.lowest_alt_m   = st_nxt.min_altitude;
    res.best_climb_cms = st_nxt.max_climb_rate;
    res.worst_sink_cms = st_nxt.max_sink_rate;
  end

endmodule
